[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the forbidden-pair word counter.
// Every macro expects signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define FPW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpw assertion failed");

// Next-cycle implication, switched off while reset is high.
`define FPW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpw assertion failed");

`endif

[rtl/fpw_pkg.sv]
// Package of the forbidden-pair word counter: constants, codes, chain types
// and modular helpers. Depends on nothing; used by fpw_cell and the top level.
`timescale 1ns / 1ps

package fpw_pkg;

  localparam int FPW_MAX_LETTERS = 32;
  // Index and count widths cover the full parameter range of up to 64 letters.
  localparam int IDX_W   = 6;
  localparam int COUNT_W = 7;
  localparam int VAL_W   = 20;

  localparam logic [VAL_W-1:0] COUNT_MOD  = 20'd666013;
  // floor(2^39 / modulus), used for the reduction of a 39-bit product.
  localparam logic [VAL_W-1:0] BARRETT_MU = 20'd825443;
  localparam logic [5:0]       LETTERS_RESET = 6'd32;

  typedef enum logic [1:0] {
    CMD_FORBID  = 2'd0,
    CMD_COMPUTE = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    IT_NONE,
    IT_MAC,
    IT_SUM
  } item_kind_t;

  typedef enum logic [1:0] {
    SW_NONE,
    SW_INIT,
    SW_COPY_BASE,
    SW_COPY_ACC
  } sweep_op_t;

  // Work item handed from cell to cell, one hop per cycle.
  typedef struct packed {
    item_kind_t       kind;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] t;
    logic             first;
    logic             last;
    logic [VAL_W-1:0] b;
  } item_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic [COUNT_W-1:0] m;
    logic               x_base;
    sweep_op_t          op;
    logic [IDX_W-1:0]   sw_c;
    logic [IDX_W-1:0]   feed_addr;
    logic               forbid;
    logic [IDX_W-1:0]   f_row;
    logic [IDX_W-1:0]   f_col;
    logic               clear;
  } cell_ctrl_t;

  function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, COUNT_MOD}) s = s - {1'b0, COUNT_MOD};
    return s[VAL_W-1:0];
  endfunction

  // Brings a value below four times the modulus into range.
  function automatic logic [VAL_W-1:0] mod_fold(input logic [VAL_W+1:0] r);
    logic [VAL_W+1:0] v;
    v = r;
    if (v >= {1'b0, COUNT_MOD, 1'b0}) v = v - {1'b0, COUNT_MOD, 1'b0};
    if (v >= {2'b00, COUNT_MOD}) v = v - {2'b00, COUNT_MOD};
    return v[VAL_W-1:0];
  endfunction

endpackage

[rtl/fpw_cell.sv]
// One cell of the chain: holds one row of the allowed, base, accumulator and
// scratch matrices, and a pipelined modular multiply-accumulate. Uses fpw_pkg.
`timescale 1ns / 1ps

module fpw_cell import fpw_pkg::*; #(
  parameter int MAX_LETTERS = FPW_MAX_LETTERS,
  parameter int CELL_INDEX  = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  item_t            item_in,
  input  logic [VAL_W-1:0] psum_in,
  output item_t            item_out,
  output logic [VAL_W-1:0] psum_out,
  output logic             psum_vld_out,
  output logic [VAL_W-1:0] feed_data
);

  localparam int IW = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;

  typedef struct packed {
    logic             v;
    logic [IDX_W-1:0] c;
    logic             first;
    logic             last;
  } mac_tag_t;

  logic [MAX_LETTERS-1:0] allowed;
  logic [VAL_W-1:0] base_mem [MAX_LETTERS];
  logic [VAL_W-1:0] acc_mem  [MAX_LETTERS];
  logic [VAL_W-1:0] scr_mem  [MAX_LETTERS];

  item_t            it;
  item_kind_t       s1_kind;
  mac_tag_t         s1_tag, s2_tag, s3_tag, s4_tag, s5_tag;
  logic [VAL_W-1:0] s1_b;
  logic [VAL_W-1:0] rd_a, rd_s;
  logic [IDX_W-1:0] addr_a;
  sweep_op_t        cp_op;
  logic [IDX_W-1:0] cp_c;
  logic [39:0]      p2, p3;
  logic [41:0]      q_prod;
  logic [VAL_W-1:0] q3;
  logic [VAL_W+1:0] r4;
  logic [VAL_W-1:0] r5;
  logic [VAL_W-1:0] macc;
  logic [VAL_W-1:0] acc_new;
  logic             active;

  assign item_out = it;
  assign active   = CELL_INDEX < int'(ctrl.m);
  // A sum transaction reads the accumulator at its column, a MAC at its step.
  assign addr_a   = (it.kind == IT_SUM) ? it.c : it.t;
  assign q_prod   = 42'(p2[39:18]) * 42'(BARRETT_MU);
  assign acc_new  = s5_tag.first ? r5 : mod_add(macc, r5);

  always_ff @(posedge clk) begin
    if (rst) begin
      allowed <= '1;
    end else if (ctrl.clear) begin
      allowed <= '1;
    end else if (ctrl.forbid && ctrl.f_row == IDX_W'(CELL_INDEX)) begin
      allowed[ctrl.f_col[IW-1:0]] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      it      <= '0;
      s1_kind <= IT_NONE;
      s1_tag  <= '0;
      s2_tag  <= '0;
      s3_tag  <= '0;
      s4_tag  <= '0;
      s5_tag  <= '0;
      cp_op   <= SW_NONE;
      psum_vld_out <= 1'b0;
    end else begin
      it      <= item_in;
      s1_kind <= it.kind;
      s1_tag  <= '{v: it.kind == IT_MAC, c: it.c, first: it.first, last: it.last};
      s2_tag  <= s1_tag;
      s3_tag  <= s2_tag;
      s4_tag  <= s3_tag;
      s5_tag  <= s4_tag;
      cp_op   <= ctrl.op;
      psum_vld_out <= (s1_kind == IT_SUM);
    end
  end

  // Read ports and the arithmetic pipeline.
  always_ff @(posedge clk) begin
    rd_a      <= ctrl.x_base ? base_mem[addr_a[IW-1:0]] : acc_mem[addr_a[IW-1:0]];
    feed_data <= base_mem[ctrl.feed_addr[IW-1:0]];
    rd_s      <= scr_mem[ctrl.sw_c[IW-1:0]];
    cp_c      <= ctrl.sw_c;
    s1_b      <= it.b;
    p2        <= 40'(rd_a) * 40'(s1_b);
    p3        <= p2;
    q3        <= q_prod[40:21];
    r4        <= (VAL_W + 2)'(p3 - 40'(q3) * 40'(COUNT_MOD));
    r5        <= mod_fold(r4);
    psum_out  <= active ? mod_add(psum_in, rd_a) : psum_in;
  end

  always_ff @(posedge clk) begin
    if (s5_tag.v) begin
      macc <= acc_new;
      if (s5_tag.last) scr_mem[s5_tag.c[IW-1:0]] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == SW_INIT) begin
      base_mem[ctrl.sw_c[IW-1:0]] <= {{(VAL_W-1){1'b0}}, allowed[ctrl.sw_c[IW-1:0]]};
    end else if (cp_op == SW_COPY_BASE) begin
      base_mem[cp_c[IW-1:0]] <= rd_s;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == SW_INIT) begin
      acc_mem[ctrl.sw_c[IW-1:0]] <=
        (ctrl.sw_c == IDX_W'(CELL_INDEX)) ? VAL_W'(1) : '0;
    end else if (cp_op == SW_COPY_ACC) begin
      acc_mem[cp_c[IW-1:0]] <= rd_s;
    end
  end

endmodule

[rtl/forbidden_pair_word_counter.sv]
// Top level of the forbidden-pair word counter: sequencer and chain of cells.
// Depends on fpw_pkg, fpw_cell and assert_macros.svh.
//
//   channel | signals                                          | direction
//   input   | in_valid/in_ready, command, first_letter,        | in
//           | second_letter, word_length                       |
//   output  | out_valid/out_ready, word_count                  | out
//   config  | cfg_write, cfg_data (letters in use)             | in
//
// Forbid and clear are taken without leaving idle; a compute with n of zero or one goes
// straight to the result. Otherwise a compute runs P = L-1 + popcount(n-1) matrix products,
// L the bit length of n-1, each fed one base element per cycle.
// Reset is synchronous; it restores an all-allowed matrix and 32 letters.
// A result waiting for out_ready holds the sequencer but nothing is lost.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module forbidden_pair_word_counter import fpw_pkg::*; #(
  parameter int MAX_LETTERS = FPW_MAX_LETTERS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [4:0]  first_letter,
  input  logic [4:0]  second_letter,
  input  logic [30:0] word_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] word_count,
  input  logic        cfg_write,
  input  logic [5:0]  cfg_data
);

  localparam int IW        = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
  localparam int DRAIN_LEN = MAX_LETTERS + 10;
  localparam int DW        = $clog2(DRAIN_LEN + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_CHECK, S_SQCHECK, S_FEED, S_DRAIN, S_COPY,
    S_SUMFEED, S_SUMDRAIN, S_DONE
  } state_t;

  typedef struct packed {
    item_kind_t       kind;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] t;
  } feed_t;

  state_t             state;
  logic [5:0]         letters;
  logic [COUNT_W-1:0] m_act, m_last;
  logic [30:0]        exp_left;
  logic               sq;
  logic [IDX_W-1:0]   fc, ft, sw_c;
  logic [DW-1:0]      dcnt;
  logic [VAL_W-1:0]   total;
  feed_t              f1;
  item_t              inj;
  cell_ctrl_t         ctrl;
  logic               accept;
  logic               sum_vld;

  item_t            chain [MAX_LETTERS+1];
  logic [VAL_W-1:0] psum  [MAX_LETTERS+1];
  logic [VAL_W-1:0] rd_b  [MAX_LETTERS];

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (letters == '0) m_act = COUNT_W'(1);
    else if (int'(letters) > MAX_LETTERS) m_act = COUNT_W'(MAX_LETTERS);
    else m_act = COUNT_W'(letters);
  end
  assign m_last = m_act - COUNT_W'(1);

  always_comb begin
    ctrl.m         = m_act;
    ctrl.x_base    = sq && (state == S_FEED || state == S_DRAIN);
    ctrl.op        = SW_NONE;
    if (state == S_INIT) ctrl.op = SW_INIT;
    else if (state == S_COPY) ctrl.op = sq ? SW_COPY_BASE : SW_COPY_ACC;
    ctrl.sw_c      = sw_c;
    ctrl.feed_addr = fc;
    ctrl.forbid    = accept && command == CMD_FORBID &&
                     int'(first_letter) < MAX_LETTERS && int'(second_letter) < MAX_LETTERS;
    ctrl.f_row     = IDX_W'(first_letter);
    ctrl.f_col     = IDX_W'(second_letter);
    ctrl.clear     = accept && command == CMD_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) letters <= LETTERS_RESET;
    else if (cfg_write) letters <= cfg_data;
  end

  // Feed stage: one base element read per cycle, injected into the first cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      inj <= '0;
    end else begin
      inj.kind  <= f1.kind;
      inj.c     <= f1.c;
      inj.t     <= f1.t;
      inj.first <= (f1.t == '0);
      inj.last  <= ({1'b0, f1.t} == m_last);
      inj.b     <= rd_b[f1.t[IW-1:0]];
    end
  end

  assign chain[0] = inj;
  assign psum[0]  = '0;

  for (genvar k = 0; k < MAX_LETTERS; k++) begin : g_cell
    if (k == MAX_LETTERS - 1) begin : g_last
      fpw_cell #(.MAX_LETTERS(MAX_LETTERS), .CELL_INDEX(k)) u_cell (
        .clk, .rst, .ctrl,
        .item_in(chain[k]), .psum_in(psum[k]),
        .item_out(chain[k+1]), .psum_out(psum[k+1]), .psum_vld_out(sum_vld),
        .feed_data(rd_b[k])
      );
    end else begin : g_mid
      fpw_cell #(.MAX_LETTERS(MAX_LETTERS), .CELL_INDEX(k)) u_cell (
        .clk, .rst, .ctrl,
        .item_in(chain[k]), .psum_in(psum[k]),
        .item_out(chain[k+1]), .psum_out(psum[k+1]), .psum_vld_out(),
        .feed_data(rd_b[k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      exp_left  <= '0;
      sq        <= 1'b0;
      f1        <= '0;
      fc        <= '0;
      ft        <= '0;
      sw_c      <= '0;
      dcnt      <= '0;
      total     <= '0;
    end else begin
      if (state != S_FEED && state != S_SUMFEED) f1.kind <= IT_NONE;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      if (sum_vld) total <= mod_add(total, psum[MAX_LETTERS]);
      unique case (state)
        S_IDLE: begin
          if (accept && command == CMD_COMPUTE) begin
            if (word_length == '0) begin
              total <= '0;
              state <= S_DONE;
            end else if (word_length == 31'd1) begin
              total <= VAL_W'(m_act);
              state <= S_DONE;
            end else begin
              exp_left <= word_length - 31'd1;
              sw_c     <= '0;
              state    <= S_INIT;
            end
          end
        end
        S_INIT: begin
          sw_c <= sw_c + 1'b1;
          if ({1'b0, sw_c} == m_last) state <= S_CHECK;
        end
        S_CHECK: begin
          fc <= '0;
          ft <= '0;
          if (exp_left == '0) begin
            total <= '0;
            state <= S_SUMFEED;
          end else if (exp_left[0]) begin
            sq    <= 1'b0;
            state <= S_FEED;
          end else begin
            exp_left <= exp_left >> 1;
            state    <= S_SQCHECK;
          end
        end
        S_SQCHECK: begin
          fc <= '0;
          ft <= '0;
          if (exp_left != '0) begin
            sq    <= 1'b1;
            state <= S_FEED;
          end else begin
            total <= '0;
            state <= S_SUMFEED;
          end
        end
        S_FEED: begin
          f1 <= '{kind: IT_MAC, c: fc, t: ft};
          if ({1'b0, ft} == m_last) begin
            ft <= '0;
            fc <= fc + 1'b1;
            if ({1'b0, fc} == m_last) begin
              dcnt  <= '0;
              state <= S_DRAIN;
            end
          end else begin
            ft <= ft + 1'b1;
          end
        end
        S_DRAIN: begin
          dcnt <= dcnt + 1'b1;
          if (dcnt == DW'(DRAIN_LEN - 1)) begin
            sw_c  <= '0;
            state <= S_COPY;
          end
        end
        S_COPY: begin
          sw_c <= sw_c + 1'b1;
          if ({1'b0, sw_c} == m_last) begin
            if (sq) begin
              state <= S_CHECK;
            end else begin
              exp_left <= exp_left >> 1;
              state    <= S_SQCHECK;
            end
          end
        end
        S_SUMFEED: begin
          f1 <= '{kind: IT_SUM, c: fc, t: '0};
          fc <= fc + 1'b1;
          if ({1'b0, fc} == m_last) begin
            dcnt  <= '0;
            state <= S_SUMDRAIN;
          end
        end
        S_SUMDRAIN: begin
          dcnt <= dcnt + 1'b1;
          if (dcnt == DW'(DRAIN_LEN - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            word_count <= total;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FPW_ASSERT_IMP(a_feed_needs_exponent, state == S_FEED, exp_left != '0)
  `FPW_ASSERT_IMP(a_result_in_range, out_valid, word_count < COUNT_MOD)
  `FPW_ASSERT_NXT(a_compute_busy, accept && command == CMD_COMPUTE, !in_ready)

endmodule
